/* rtl/twodo_pkg.sv */
// Package for the tracking wheel odometry core: turn constants, reciprocal
// constants, register indexes and the CORDIC angle table.
// No dependencies.
`default_nettype none

package twodo_pkg;

  localparam int unsigned TICK_RATE_DEF    = 100;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // heading units are 1/256 degree
  localparam logic [16:0] FULL_TURN = 17'd92160;
  localparam logic [17:0] DBL_TURN  = 18'd184320;

  // radians in Q32 per heading unit
  localparam logic [31:0] RAD_Q32  = 32'd292818;
  // inverse CORDIC gain in Q30
  localparam logic [31:0] INV_GAIN = 32'd652032874;
  // ceil(2^44 / 45): phi * 2^20 / 45 as (phi * RECIP_45) >> 24
  localparam logic [45:0] RECIP_45 = 46'd390937467654;
  // ceil(2^24 / 3): x / 3 as (x * RECIP_3) >> 24
  localparam logic [45:0] RECIP_3  = 46'd5592406;

  localparam logic [7:0] CFG_X_OFF   = 8'd0;
  localparam logic [7:0] CFG_Y_OFF   = 8'd1;
  localparam logic [7:0] CFG_START_X = 8'd2;
  localparam logic [7:0] CFG_START_Y = 8'd3;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // magnitude of a sign-extended value
  function automatic logic [45:0] mag46(input logic signed [45:0] x);
    return x[45] ? 46'(-x) : 46'(x);
  endfunction

endpackage

`default_nettype wire

/* rtl/tracking_wheel_odometry_core.sv */
// Tracking wheel odometry core: pose accumulation from two wheels and a heading.
// Uses twodo_pkg. Shared 46x32 multiplier (8 bits a cycle), square root and
// CORDIC steps run under one sequencer.
//
// Usage: configure wheel offsets and start pose over the cfg channel (index,
// data, valid/ready; ready is always high) while the core is idle. Writing a
// start register loads that pose coordinate at once. Each input transaction is
// one sensor tick (two cumulative wheel distances and a clockwise heading).
// The first tick after reset only seeds the previous readings and returns the
// pose with zero speed and turn rate through the finish state.
// Every later tick holds the input while the core runs fourteen multiplies on
// the shared multiplier, 32 square root steps, the CORDIC rotation and a
// finish state. A speed overflow skips the root and one multiply.
// in_stall_o is high while a tick is worked on. The result sits in an output
// register; the next tick is taken while it waits, and the core holds its
// finished result until a stalled receiver drops out_stall_i.
// Reset clears the accumulated pose, the wheel offsets and the seeded flag.
`default_nettype none

module tracking_wheel_odometry_core
  import twodo_pkg::*;
#(
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [7:0]  cfg_index_i,
  input  wire logic        [47:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] side_wheel_dist_i,
  input  wire logic signed [31:0] fwd_wheel_dist_i,
  input  wire logic        [16:0] imu_heading_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      pose_x_o,
  output logic signed [47:0]      pose_y_o,
  output logic        [16:0]      pose_heading_o,
  output logic        [31:0]      linear_speed_o,
  output logic signed [23:0]      turn_rate_o
);

  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_MSET, S_MUL, S_MRES, S_SQRT, S_CORDIC, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_RATE, OP_AXSQ, OP_AYSQ, OP_SPEED, OP_RAD, OP_XOFF, OP_YOFF,
    OP_TSQ, OP_DIV3, OP_LX, OP_LY, OP_BAM, OP_GU, OP_GV
  } op_e;

  state_e state_q;
  op_e    op_q;

  // control and architectural state
  logic signed [19:0] x_off_q, y_off_q;
  logic signed [47:0] acc_x_q, acc_y_q;
  logic signed [31:0] last_side_q, last_fwd_q;
  logic        [16:0] last_heading_q;
  logic               seeded_q;
  logic               out_valid_q;
  logic        [1:0]  mcnt_q;
  logic        [4:0]  sq_k_q;
  logic [STEP_W-1:0]  step_q;

  // datapath
  logic signed [32:0] dx_q, dy_q;
  logic signed [16:0] d_q;
  logic        [16:0] h_q;
  logic        [45:0] a_q;
  logic        [31:0] b_q;
  logic               neg_q;
  logic        [77:0] p_q;
  logic        [64:0] sum_q;
  logic        [63:0] sq_x_q, sq_r_q;
  logic signed [35:0] rad_q;
  logic signed [42:0] lx_q, ly_q;
  logic        [20:0] divx_q, f_q;
  logic signed [45:0] u_q, v_q;
  logic signed [33:0] z_q;
  logic        [31:0] speed_q;
  logic signed [23:0] rate_q;
  logic signed [47:0] pose_x_q, pose_y_q;
  logic        [16:0] pose_heading_q;
  logic        [31:0] linear_speed_q;
  logic signed [23:0] turn_rate_q;

  logic in_acc, cfg_acc, fin_go;
  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign cfg_acc = cfg_valid_i;
  assign fin_go  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // tick front end
  logic        [16:0] imu_adj, h_new;
  logic signed [17:0] d_raw, d_wrap;
  logic signed [32:0] dx_new, dy_new;

  always_comb begin
    imu_adj = (imu_heading_i >= FULL_TURN) ? imu_heading_i - FULL_TURN : imu_heading_i;
    h_new   = FULL_TURN - imu_adj;
    d_raw   = $signed({1'b0, h_new}) - $signed({1'b0, last_heading_q});
    if (d_raw > 18'sd46080) begin
      d_wrap = d_raw - 18'sd92160;
    end else if (d_raw < -18'sd46080) begin
      d_wrap = d_raw + 18'sd92160;
    end else begin
      d_wrap = d_raw;
    end
    dx_new = 33'(side_wheel_dist_i) - 33'(last_side_q);
    dy_new = 33'(fwd_wheel_dist_i) - 33'(last_fwd_q);
  end

  // midpoint angle in 1/512 degree, reduced to one turn
  logic signed [18:0] phi_raw;
  logic        [17:0] phi;
  always_comb begin
    phi_raw = $signed({1'b0, h_q, 1'b0}) - 19'(d_q);
    if (phi_raw < 19'sd0) begin
      phi = 18'(phi_raw + 19'sd184320);
    end else if (phi_raw >= $signed({1'b0, DBL_TURN})) begin
      phi = 18'(phi_raw - 19'sd184320);
    end else begin
      phi = 18'(phi_raw);
    end
  end

  // operand select for the shared multiplier
  logic signed [27:0] t_val;
  logic [45:0] d_mag, dx_mag, dy_mag, rad_mag, xo_mag, yo_mag, t_mag;
  logic [45:0] lx_mag, ly_mag, u_mag, v_mag;
  logic [45:0] op_a;
  logic [31:0] op_b;
  logic        op_neg;

  always_comb begin
    t_val   = 28'(rad_q >>> 8);
    d_mag   = mag46(46'(d_q));
    dx_mag  = mag46(46'(dx_q));
    dy_mag  = mag46(46'(dy_q));
    rad_mag = mag46(46'(rad_q));
    xo_mag  = mag46(46'(x_off_q));
    yo_mag  = mag46(46'(y_off_q));
    t_mag   = mag46(46'(t_val));
    lx_mag  = mag46(46'(lx_q));
    ly_mag  = mag46(46'(ly_q));
    u_mag   = mag46(u_q);
    v_mag   = mag46(v_q);
    op_a    = '0;
    op_b    = '0;
    op_neg  = 1'b0;
    unique case (op_q)
      OP_RATE:  begin op_a = d_mag;  op_b = 32'(TICK_RATE_HZ); op_neg = d_q[16]; end
      OP_AXSQ:  begin op_a = dx_mag; op_b = dx_mag[31:0]; end
      OP_AYSQ:  begin op_a = dy_mag; op_b = dy_mag[31:0]; end
      OP_SPEED: begin op_a = 46'(sq_r_q[31:0]); op_b = 32'(TICK_RATE_HZ); end
      OP_RAD:   begin op_a = d_mag;  op_b = RAD_Q32; op_neg = d_q[16]; end
      OP_XOFF:  begin
        op_a = rad_mag; op_b = xo_mag[31:0]; op_neg = rad_q[35] ^ x_off_q[19];
      end
      OP_YOFF:  begin
        op_a = rad_mag; op_b = yo_mag[31:0]; op_neg = rad_q[35] ^ y_off_q[19];
      end
      OP_TSQ:   begin op_a = t_mag; op_b = t_mag[31:0]; end
      OP_DIV3:  begin op_a = RECIP_3; op_b = 32'(divx_q); end
      OP_LX:    begin op_a = lx_mag; op_b = 32'(f_q); op_neg = lx_q[42]; end
      OP_LY:    begin op_a = ly_mag; op_b = 32'(f_q); op_neg = ly_q[42]; end
      OP_BAM:   begin op_a = RECIP_45; op_b = 32'(phi); end
      OP_GU:    begin op_a = u_mag; op_b = INV_GAIN; op_neg = u_q[45]; end
      OP_GV:    begin op_a = v_mag; op_b = INV_GAIN; op_neg = v_q[45]; end
      default:  begin op_a = '0; op_b = '0; op_neg = 1'b0; end
    endcase
  end

  // multiplier result and derived values
  logic        [53:0] mul_part;
  logic signed [78:0] m_s;
  logic        [64:0] sum_next;
  logic signed [45:0] gain_g, gain_r;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_sat;
  logic        [31:0] bam, bam_f;
  logic               fold;

  always_comb begin
    mul_part = 54'(a_q) * 54'(b_q[31:24]);
    m_s      = neg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
    sum_next = sum_q + p_q[64:0];
    gain_g   = 46'(m_s >>> 30);
    gain_r   = (gain_g + 46'sd128) >>> 8;
    acc_sum  = (op_q == OP_GU) ? 49'(acc_x_q) + 49'(gain_r) : 49'(acc_y_q) + 49'(gain_r);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_sat = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_sat = acc_sum[47:0];
    end
    bam   = p_q[55:24];
    fold  = bam[31] ^ bam[30];
    bam_f = fold ? {~bam[31], bam[30:0]} : bam;
  end

  // square root and CORDIC step logic
  logic [63:0] sq_bit, sq_rb;
  logic signed [45:0] cu, cv;
  logic [31:0] atan_v;
  always_comb begin
    sq_bit = 64'd1 << {sq_k_q, 1'b0};
    sq_rb  = sq_r_q + sq_bit;
    cu     = v_q >>> step_q;
    cv     = u_q >>> step_q;
    atan_v = atan_bam(5'(step_q));
  end

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= OP_RATE;
      x_off_q        <= '0;
      y_off_q        <= '0;
      acc_x_q        <= '0;
      acc_y_q        <= '0;
      last_side_q    <= '0;
      last_fwd_q     <= '0;
      last_heading_q <= '0;
      seeded_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      mcnt_q         <= '0;
      sq_k_q         <= '0;
      step_q         <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          CFG_X_OFF:   x_off_q <= $signed(cfg_data_i[19:0]);
          CFG_Y_OFF:   y_off_q <= $signed(cfg_data_i[19:0]);
          CFG_START_X: acc_x_q <= $signed(cfg_data_i);
          CFG_START_Y: acc_y_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_side_q    <= side_wheel_dist_i;
            last_fwd_q     <= fwd_wheel_dist_i;
            last_heading_q <= h_new;
            seeded_q       <= 1'b1;
            op_q           <= OP_RATE;
            state_q        <= seeded_q ? S_MSET : S_FIN;
          end
        end
        S_MSET: begin
          mcnt_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            state_q <= S_MRES;
          end
        end
        S_MRES: begin
          unique case (op_q)
            OP_AYSQ: begin
              if (sum_next[64]) begin
                op_q    <= OP_RAD;
                state_q <= S_MSET;
              end else begin
                sq_k_q  <= 5'd31;
                state_q <= S_SQRT;
              end
            end
            OP_BAM: begin
              step_q  <= '0;
              state_q <= S_CORDIC;
            end
            OP_GU: begin
              acc_x_q <= acc_sat;
              op_q    <= OP_GV;
              state_q <= S_MSET;
            end
            OP_GV: begin
              acc_y_q <= acc_sat;
              state_q <= S_FIN;
            end
            default: begin
              op_q    <= op_e'(op_q + 4'd1);
              state_q <= S_MSET;
            end
          endcase
        end
        S_SQRT: begin
          sq_k_q <= sq_k_q - 5'd1;
          if (sq_k_q == 5'd0) begin
            op_q    <= OP_SPEED;
            state_q <= S_MSET;
          end
        end
        S_CORDIC: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            op_q    <= OP_GU;
            state_q <= S_MSET;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q    <= dx_new;
      dy_q    <= dy_new;
      d_q     <= 17'(d_wrap);
      h_q     <= h_new;
      speed_q <= '0;
      rate_q  <= '0;
    end
    if (state_q == S_MSET) begin
      a_q   <= op_a;
      b_q   <= op_b;
      neg_q <= op_neg;
      p_q   <= '0;
    end
    if (state_q == S_MUL) begin
      p_q <= (p_q << 8) + 78'(mul_part);
      b_q <= b_q << 8;
    end
    if (state_q == S_MRES) begin
      case (op_q)
        OP_RATE: begin
          if (m_s > 79'sd8388607) begin
            rate_q <= 24'sh7FFFFF;
          end else if (m_s < -79'sd8388608) begin
            rate_q <= -24'sh800000;
          end else begin
            rate_q <= m_s[23:0];
          end
        end
        OP_AXSQ: sum_q <= p_q[64:0];
        OP_AYSQ: begin
          sum_q  <= sum_next;
          sq_x_q <= sum_next[63:0];
          sq_r_q <= '0;
          if (sum_next[64]) begin
            speed_q <= '1;
          end
        end
        OP_SPEED: speed_q <= (|p_q[77:32]) ? '1 : p_q[31:0];
        OP_RAD:   rad_q <= m_s[35:0];
        OP_XOFF:  lx_q <= 43'($signed({dx_q, 8'b0})) - 43'(m_s >>> 24);
        OP_YOFF:  ly_q <= 43'($signed({dy_q, 8'b0})) + 43'(m_s >>> 24);
        OP_TSQ:   divx_q <= p_q[51:31];
        OP_DIV3:  f_q <= 21'h100000 - p_q[44:24];
        OP_LX:    lx_q <= 43'(m_s >>> 20);
        OP_LY:    ly_q <= 43'(m_s >>> 20);
        OP_BAM: begin
          // fold the left half-plane by negating the vector
          u_q <= fold ? -46'(ly_q) : 46'(ly_q);
          v_q <= fold ? -46'(lx_q) : 46'(lx_q);
          z_q <= 34'($signed(bam_f));
        end
        default: ;
      endcase
    end
    if (state_q == S_SQRT) begin
      if (sq_x_q >= sq_rb) begin
        sq_x_q <= sq_x_q - sq_rb;
        sq_r_q <= (sq_r_q >> 1) + sq_bit;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
    end
    if (state_q == S_CORDIC) begin
      if (!z_q[33]) begin
        u_q <= u_q - cu;
        v_q <= v_q + cv;
        z_q <= z_q - $signed({2'b0, atan_v});
      end else begin
        u_q <= u_q + cu;
        v_q <= v_q - cv;
        z_q <= z_q + $signed({2'b0, atan_v});
      end
    end
    if (fin_go) begin
      pose_x_q       <= acc_x_q;
      pose_y_q       <= acc_y_q;
      pose_heading_q <= h_q;
      linear_speed_q <= speed_q;
      turn_rate_q    <= rate_q;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pose_x_o       = pose_x_q;
  assign pose_y_o       = pose_y_q;
  assign pose_heading_o = pose_heading_q;
  assign linear_speed_o = linear_speed_q;
  assign turn_rate_o    = turn_rate_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("core not busy after taking a tick");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o && !in_stall_o)
    else $error("finished tick did not reach the output register");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pose_heading_o != 17'd0) && (pose_heading_o <= FULL_TURN))
    else $error("reported heading out of range");

  a_sqrt_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> !sum_q[64])
    else $error("square root entered with overflowed sum");

endmodule

`default_nettype wire
